@@ src/qfa_pkg.sv @@
package qfa_pkg;

  localparam int unsigned IndexWidth = 32;

  typedef logic [IndexWidth-1:0] index_t;

  // vertices seen in the current polygon, saturating
  typedef logic [1:0] seen_t;
  localparam seen_t SEEN_NONE = 2'd0;
  localparam seen_t SEEN_ONE  = 2'd1;
  localparam seen_t SEEN_MANY = 2'd3;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

  typedef struct packed {
    index_t corner_a;
    index_t corner_b;
    index_t corner_c;
    index_t corner_d;
    logic   is_last_quad;
    logic   status;
  } quad_t;

  typedef struct packed {
    logic  emit;
    quad_t quad;
  } fan_result_t;

endpackage

@@ src/qfa_stream_if.sv @@
interface qfa_vertex_if;
  logic             valid;
  logic             ready;
  qfa_pkg::index_t  vertex_index;
  logic             is_last_vertex;

  modport source (output valid, output vertex_index, output is_last_vertex, input ready);
  modport sink   (input valid, input vertex_index, input is_last_vertex, output ready);
endinterface

interface qfa_quad_if;
  logic             valid;
  logic             ready;
  qfa_pkg::index_t  corner_a;
  qfa_pkg::index_t  corner_b;
  qfa_pkg::index_t  corner_c;
  qfa_pkg::index_t  corner_d;
  logic             is_last_quad;
  logic             status;

  modport source (output valid, output corner_a, output corner_b, output corner_c,
                  output corner_d, output is_last_quad, output status, input ready);
  modport sink   (input valid, input corner_a, input corner_b, input corner_c,
                  input corner_d, input is_last_quad, input status, output ready);
endinterface

@@ src/qfa_fan_core.sv @@
module qfa_fan_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  qfa_pkg::index_t       vertex_index,
  input  logic                  is_last_vertex,
  output qfa_pkg::fan_result_t  result
);

  qfa_pkg::index_t fan_origin;
  qfa_pkg::index_t held_odd_vertex;
  qfa_pkg::index_t held_even_vertex;
  qfa_pkg::seen_t  seen_count;
  logic            position_parity;

  always_comb begin
    result.emit              = is_last_vertex;
    result.quad.corner_a     = fan_origin;
    result.quad.corner_b     = held_odd_vertex;
    result.quad.corner_c     = vertex_index;
    result.quad.corner_d     = held_even_vertex;
    result.quad.is_last_quad = 1'b1;
    result.quad.status       = qfa_pkg::STATUS_OK;
    unique case (seen_count)
      qfa_pkg::SEEN_NONE: begin
        result.quad.corner_a = '0;
        result.quad.corner_b = '0;
        result.quad.corner_c = '0;
        result.quad.corner_d = '0;
        result.quad.status   = qfa_pkg::STATUS_SHORT;
      end
      qfa_pkg::SEEN_ONE: begin
        // line quad
        result.quad.corner_b = fan_origin;
        result.quad.corner_d = vertex_index;
      end
      default: begin
        if (!position_parity) begin
          // closing degenerate quad, only if this is the last vertex
          result.quad.corner_c = fan_origin;
          result.quad.corner_d = vertex_index;
        end else begin
          result.emit              = 1'b1;
          result.quad.is_last_quad = is_last_vertex;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fan_origin       <= '0;
      held_odd_vertex  <= '0;
      held_even_vertex <= '0;
      seen_count       <= qfa_pkg::SEEN_NONE;
      position_parity  <= 1'b0;
    end else if (fire) begin
      unique case (seen_count)
        qfa_pkg::SEEN_NONE: fan_origin      <= vertex_index;
        qfa_pkg::SEEN_ONE:  held_odd_vertex <= vertex_index;
        default: begin
          if (position_parity) held_odd_vertex <= vertex_index;
          else held_even_vertex <= vertex_index;
        end
      endcase
      if (is_last_vertex) begin
        seen_count      <= qfa_pkg::SEEN_NONE;
        position_parity <= 1'b0;
      end else begin
        if (seen_count != qfa_pkg::SEEN_MANY) seen_count <= seen_count + 2'd1;
        position_parity <= ~position_parity;
      end
    end
  end

endmodule

@@ src/qfa_out_reg.sv @@
module qfa_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  qfa_pkg::quad_t       quad_next,
  output logic                 can_load,
  qfa_quad_if.source           quad
);

  logic           valid;
  qfa_pkg::quad_t held;

  assign can_load = !valid || quad.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      held <= quad_next;
    end
  end

  assign quad.valid        = valid;
  assign quad.corner_a     = held.corner_a;
  assign quad.corner_b     = held.corner_b;
  assign quad.corner_c     = held.corner_c;
  assign quad.corner_d     = held.corner_d;
  assign quad.is_last_quad = held.is_last_quad;
  assign quad.status       = held.status;

endmodule

@@ src/polygon_quad_fan_assembler_core.sv @@
// Quad fan assembler.
// vertex: one polygon vertex index per transfer, is_last_vertex on the final
//   one. The next transfer starts a new polygon.
// quad:   quad patches in fan order around the first vertex, third and fourth
//   corners swapped from patch order. Every closed polygon ends with exactly one
//   transfer that has is_last_quad set; a one-vertex polygon gives status 1 and
//   zero corners.
// A vertex transfer passes through the input register, then the result register,
//   on its way to the quad it completes. Vertices that complete nothing leave no
//   transfer on quad.
// Throughput: one vertex per cycle while quad does not stall; the fan state
//   updates as each vertex leaves the input register.
// Reset clears the fan state and both valid flags; the next vertex starts a
//   new polygon.
// A stall on quad holds the result register; one more vertex waits in the
//   input register, after which vertex.ready drops until quad drains.
module polygon_quad_fan_assembler_core (
  input logic          clk,
  input logic          rst,
  qfa_vertex_if.sink   vertex,
  qfa_quad_if.source   quad
);

  logic                 in_valid;
  qfa_pkg::index_t      in_index;
  logic                 in_last;
  logic                 out_can_load;
  logic                 advance;
  qfa_pkg::fan_result_t result;

  assign advance      = in_valid && out_can_load;
  assign vertex.ready = !in_valid || out_can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (vertex.ready) begin
      in_valid <= vertex.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (vertex.ready && vertex.valid) begin
      in_index <= vertex.vertex_index;
      in_last  <= vertex.is_last_vertex;
    end
  end

  qfa_fan_core u_fan (
    .clk            (clk),
    .rst            (rst),
    .fire           (advance),
    .vertex_index   (in_index),
    .is_last_vertex (in_last),
    .result         (result)
  );

  qfa_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && result.emit),
    .quad_next (result.quad),
    .can_load  (out_can_load),
    .quad      (quad)
  );

endmodule

@@ src/qfa_checker.sv @@
module qfa_checker (
  input logic            clk,
  input logic            rst,
  input logic            vertex_ready,
  input logic            quad_valid,
  input logic            quad_ready,
  input qfa_pkg::index_t corner_a,
  input qfa_pkg::index_t corner_b,
  input qfa_pkg::index_t corner_c,
  input qfa_pkg::index_t corner_d,
  input logic            is_last_quad,
  input logic            status
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !quad_valid)
    else $error("quad valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    quad_valid && !quad_ready |=> quad_valid && $stable(corner_a) && $stable(corner_b)
      && $stable(corner_c) && $stable(corner_d) && $stable(is_last_quad)
      && $stable(status))
    else $error("stalled quad changed");

  a_short_form: assert property (@(posedge clk) disable iff (rst)
    quad_valid && status == qfa_pkg::STATUS_SHORT |->
      is_last_quad && corner_a == '0 && corner_b == '0 && corner_c == '0
      && corner_d == '0)
    else $error("malformed error result");

  // vertex side stalls only behind a stalled result
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !vertex_ready |-> quad_valid && !quad_ready)
    else $error("vertex stalled without output stall");

endmodule

bind polygon_quad_fan_assembler_core qfa_checker u_qfa_checker (
  .clk          (clk),
  .rst          (rst),
  .vertex_ready (vertex.ready),
  .quad_valid   (quad.valid),
  .quad_ready   (quad.ready),
  .corner_a     (quad.corner_a),
  .corner_b     (quad.corner_b),
  .corner_c     (quad.corner_c),
  .corner_d     (quad.corner_d),
  .is_last_quad (quad.is_last_quad),
  .status       (quad.status)
);
